// ----- rtl/core/srpf_pkg.sv -----
// ----------------------------------------------------------------------------
// srpf_pkg
// Shared constants and types for the short range pair force block.
// ----------------------------------------------------------------------------
package srpf_pkg;

    localparam int POS_FRAC_BITS = 24;

    // register indexes
    localparam logic [1:0] CFG_CUTOFF   = 2'd0;
    localparam logic [1:0] CFG_MIN_DIST = 2'd1;
    localparam logic [1:0] CFG_INV_MASS = 2'd2;

    localparam logic [23:0] CUTOFF_RST   = 24'd167772;
    localparam logic [23:0] MIN_DIST_RST = 24'd1678;
    localparam logic [31:0] INV_MASS_RST = 32'd6553600;

    localparam int SQ_STEPS = 25;                 // root bits of a 49-bit r2
    localparam int Q_BITS   = 63;                 // quotient bits below saturation
    localparam int NUM_W    = 81 + POS_FRAC_BITS; // diff*d*inv_mass << F
    localparam int REM_W    = 75;                 // divider remainder
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [23:0] cutoff;
        logic [23:0] min_dist;
        logic [31:0] inv_mass;
        logic [47:0] cutoff_sq;
        logic [47:0] min_sq;
    } t_cfg;

    // one classified pair handed from front to back
    typedef struct packed {
        logic        inter;
        logic        live;
        logic        negx;
        logic        negy;
        logic [23:0] adx;
        logic [23:0] ady;
        logic [48:0] r2;
    } t_job;

endpackage

// ----- rtl/core/srpf_front.sv -----
// ----------------------------------------------------------------------------
// srpf_front
// Takes pair beats, forms |dx|, |dy|, r2 and the cutoff decision.
// ----------------------------------------------------------------------------
module srpf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srpf_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_self_x,
    input  logic [31:0]       i_self_y,
    input  logic [31:0]       i_other_x,
    input  logic [31:0]       i_other_y,
    input  logic              i_full,
    output logic              o_push,
    output srpf_pkg::t_job    o_job
);
    import srpf_pkg::*;

    logic        r_f0_vld, n_f0_vld;
    logic        r_f0_negx, r_f0_negy;
    logic [31:0] r_f0_adx, r_f0_ady;
    logic        r_f1_vld;
    logic        r_f1_oor, r_f1_negx, r_f1_negy;
    logic [23:0] r_f1_adx, r_f1_ady;
    logic [47:0] r_f1_sqx, r_f1_sqy;
    logic        en;
    logic [48:0] r2, min_sq;

    assign en         = !(r_f1_vld && i_full);
    assign o_in_ready = en;
    assign n_f0_vld   = i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
        end else if (en) begin
            r_f0_vld <= n_f0_vld;
            r_f1_vld <= r_f0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f0_negx <= i_other_x < i_self_x;
            r_f0_negy <= i_other_y < i_self_y;
            r_f0_adx  <= (i_other_x < i_self_x) ? i_self_x - i_other_x : i_other_x - i_self_x;
            r_f0_ady  <= (i_other_y < i_self_y) ? i_self_y - i_other_y : i_other_y - i_self_y;
            r_f1_oor  <= (r_f0_adx > {8'd0, i_cfg.cutoff}) || (r_f0_ady > {8'd0, i_cfg.cutoff});
            r_f1_negx <= r_f0_negx;
            r_f1_negy <= r_f0_negy;
            r_f1_adx  <= r_f0_adx[23:0];
            r_f1_ady  <= r_f0_ady[23:0];
            r_f1_sqx  <= 48'(r_f0_adx[23:0]) * 48'(r_f0_adx[23:0]);
            r_f1_sqy  <= 48'(r_f0_ady[23:0]) * 48'(r_f0_ady[23:0]);
        end
    end

    // sum, cutoff compare and clamp to the minimum distance
    always_comb begin
        r2     = 49'(r_f1_sqx) + 49'(r_f1_sqy);
        min_sq = 49'(i_cfg.min_sq);
        o_job.inter = !r_f1_oor && (r2 <= 49'(i_cfg.cutoff_sq));
        o_job.r2    = (r2 < min_sq) ? min_sq : r2;
        o_job.live  = o_job.inter && (o_job.r2 != 49'd0);
        o_job.negx  = r_f1_negx;
        o_job.negy  = r_f1_negy;
        o_job.adx   = r_f1_adx;
        o_job.ady   = r_f1_ady;
    end

    assign o_push = r_f1_vld && !i_full;

endmodule

// ----- rtl/core/srpf_queue.sv -----
// ----------------------------------------------------------------------------
// srpf_queue
// Short queue of classified pairs between front and back.
// ----------------------------------------------------------------------------
module srpf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srpf_pkg::t_job    i_job,
    input  logic              i_pop,
    output srpf_pkg::t_job    o_job,
    output logic              o_full,
    output logic              o_empty
);
    import srpf_pkg::*;

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_cnt;

    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

// ----- rtl/core/srpf_back.sv -----
// ----------------------------------------------------------------------------
// srpf_back
// Root, products and restoring division, one step per stage, plus result reg.
// ----------------------------------------------------------------------------
module srpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srpf_pkg::t_cfg    i_cfg,
    input  srpf_pkg::t_job    i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [63:0]       o_force_x,
    output logic [63:0]       o_force_y,
    output logic              o_interacts
);
    import srpf_pkg::*;

    localparam int ST_M1  = SQ_STEPS;
    localparam int ST_M2  = SQ_STEPS + 1;
    localparam int ST_M3  = SQ_STEPS + 2;
    localparam int ST_M4  = SQ_STEPS + 3;
    localparam int ST_M5  = SQ_STEPS + 4;
    localparam int DIV0   = SQ_STEPS + 5;
    localparam int NST    = DIV0 + Q_BITS;

    typedef struct packed {
        logic              vld;
        logic              inter;
        logic              live;
        logic              negx;
        logic              negy;
        logic              negd;
        logic              satx;
        logic              saty;
        logic [23:0]       adx;
        logic [23:0]       ady;
        logic [48:0]       r2;
        logic [48:0]       sv;
        logic [49:0]       sres;
        logic [24:0]       diff;
        logic [49:0]       dlo;
        logic [48:0]       dhi;
        logic [73:0]       den;
        logic [48:0]       px;
        logic [48:0]       py;
        logic [56:0]       plx;
        logic [56:0]       ply;
        logic [55:0]       phx;
        logic [55:0]       phy;
        logic [NUM_W-1:0]  numx;
        logic [NUM_W-1:0]  numy;
        logic [REM_W-1:0]  remx;
        logic [REM_W-1:0]  remy;
        logic [Q_BITS-1:0] qx;
        logic [Q_BITS-1:0] qy;
    } t_pipe;

    t_pipe r_pl [NST];
    t_pipe n_pl [NST];
    t_pipe head;
    logic  en;
    logic  r_out_valid;
    logic [63:0] r_fx, r_fy;
    logic  r_inter;

    function automatic t_pipe f_step(input t_pipe p, input int k, input t_cfg c);
        t_pipe       o;
        logic [49:0] bit_v, trial;
        logic [24:0] r;
        logic [REM_W-1:0] tx, ty, dn;
        int j;
        o     = p;
        bit_v = '0;
        trial = '0;
        r     = p.sres[24:0];
        tx    = '0;
        ty    = '0;
        dn    = REM_W'(p.den);
        j     = 0;
        if (k < SQ_STEPS) begin
            // one root digit
            bit_v = 50'd1 << (2 * (SQ_STEPS - 1 - k));
            trial = p.sres + bit_v;
            if ({1'b0, p.sv} >= trial) begin
                o.sv   = p.sv - trial[48:0];
                o.sres = (p.sres >> 1) + bit_v;
            end else begin
                o.sres = p.sres >> 1;
            end
        end else if (k == ST_M1) begin
            o.negd = r < {1'b0, c.cutoff};
            o.diff = (r < {1'b0, c.cutoff}) ? {1'b0, c.cutoff} - r : r - {1'b0, c.cutoff};
            o.dlo  = 50'(r) * 50'(p.r2[24:0]);
            o.dhi  = 49'(r) * 49'(p.r2[48:25]);
        end else if (k == ST_M2) begin
            o.den = 74'(p.dlo) + (74'(p.dhi) << 25);
            o.px  = 49'(p.diff) * 49'(p.adx);
            o.py  = 49'(p.diff) * 49'(p.ady);
        end else if (k == ST_M3) begin
            o.plx = 57'(p.px[24:0]) * 57'(c.inv_mass);
            o.phx = 56'(p.px[48:25]) * 56'(c.inv_mass);
            o.ply = 57'(p.py[24:0]) * 57'(c.inv_mass);
            o.phy = 56'(p.py[48:25]) * 56'(c.inv_mass);
        end else if (k == ST_M4) begin
            o.numx = (NUM_W'(p.plx) + (NUM_W'(p.phx) << 25)) << POS_FRAC_BITS;
            o.numy = (NUM_W'(p.ply) + (NUM_W'(p.phy) << 25)) << POS_FRAC_BITS;
        end else if (k == ST_M5) begin
            // quotient reaches 2^63 exactly when num >> 63 >= den
            o.remx = REM_W'(p.numx[NUM_W-1:Q_BITS]);
            o.remy = REM_W'(p.numy[NUM_W-1:Q_BITS]);
            o.satx = REM_W'(p.numx[NUM_W-1:Q_BITS]) >= dn;
            o.saty = REM_W'(p.numy[NUM_W-1:Q_BITS]) >= dn;
            o.qx   = '0;
            o.qy   = '0;
        end else begin
            j  = Q_BITS - 1 - (k - DIV0);
            tx = {p.remx[REM_W-2:0], p.numx[j]};
            ty = {p.remy[REM_W-2:0], p.numy[j]};
            if (tx >= dn) begin
                o.remx  = tx - dn;
                o.qx[j] = 1'b1;
            end else begin
                o.remx = tx;
            end
            if (ty >= dn) begin
                o.remy  = ty - dn;
                o.qy[j] = 1'b1;
            end else begin
                o.remy = ty;
            end
        end
        return o;
    endfunction

    function automatic logic [63:0] f_sat(input logic [Q_BITS-1:0] q, input logic sat,
                                          input logic neg, input logic live);
        logic [63:0] v;
        if (!live)    v = '0;
        else if (sat) v = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else          v = neg ? 64'd0 - {1'b0, q} : {1'b0, q};
        return v;
    endfunction

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        head       = '0;
        head.vld   = o_pop;
        head.inter = i_job.inter;
        head.live  = i_job.live;
        head.negx  = i_job.negx;
        head.negy  = i_job.negy;
        head.adx   = i_job.adx;
        head.ady   = i_job.ady;
        head.r2    = i_job.r2;
        head.sv    = i_job.r2;
        n_pl[0]    = f_step(head, 0, i_cfg);
        for (int k = 1; k < NST; k++) begin
            n_pl[k] = f_step(r_pl[k-1], k, i_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_pl[k].vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_pl        <= n_pl;
            r_out_valid <= r_pl[NST-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx    <= f_sat(r_pl[NST-1].qx, r_pl[NST-1].satx,
                             r_pl[NST-1].negd != r_pl[NST-1].negx, r_pl[NST-1].live);
            r_fy    <= f_sat(r_pl[NST-1].qy, r_pl[NST-1].saty,
                             r_pl[NST-1].negd != r_pl[NST-1].negy, r_pl[NST-1].live);
            r_inter <= r_pl[NST-1].inter;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_force_x   = r_fx;
    assign o_force_y   = r_fy;
    assign o_interacts = r_inter;

endmodule

// ----- rtl/core/short_range_pair_force.sv -----
// ----------------------------------------------------------------------------
// short_range_pair_force
// Repulsive cutoff pair force in fixed point, one particle pair per beat.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, queue, 25 root stages (one per root digit),
//   5 product stages, 63 divider stages (one per quotient bit), result register.
// Throughput: one pair per cycle unless the receiver holds i_out_ready low.
// Reset: synchronous, active low; clears valids, queue and pointers, and loads
//   the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module short_range_pair_force (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // pair beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_self_x,
    input  logic [31:0] i_self_y,
    input  logic [31:0] i_other_x,
    input  logic [31:0] i_other_y,
    // force beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_force_x,
    output logic [63:0] o_force_y,
    output logic        o_interacts
);
    import srpf_pkg::*;

    logic [23:0] r_cutoff, r_min_dist;
    logic [31:0] r_inv_mass;
    logic [47:0] r_cutoff_sq, r_min_sq;
    t_cfg        cfg;
    t_job        push_job, head_job;
    logic        push, pop, full, empty;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff   <= CUTOFF_RST;
            r_min_dist <= MIN_DIST_RST;
            r_inv_mass <= INV_MASS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CUTOFF:   r_cutoff   <= i_cfg_data[23:0];
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[23:0];
                CFG_INV_MASS: r_inv_mass <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // squares of the static distances, registered in the cycle after the registers
    always_ff @(posedge i_clk) begin
        r_cutoff_sq <= 48'(r_cutoff) * 48'(r_cutoff);
        r_min_sq    <= 48'(r_min_dist) * 48'(r_min_dist);
    end

    assign cfg.cutoff    = r_cutoff;
    assign cfg.min_dist  = r_min_dist;
    assign cfg.inv_mass  = r_inv_mass;
    assign cfg.cutoff_sq = r_cutoff_sq;
    assign cfg.min_sq    = r_min_sq;

    // front: accept and classify
    srpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_self_x   (i_self_x),
        .i_self_y   (i_self_y),
        .i_other_x  (i_other_x),
        .i_other_y  (i_other_y),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decoupling queue
    srpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // back: root, products, division, saturation
    srpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_force_x   (o_force_x),
        .o_force_y   (o_force_y),
        .o_interacts (o_interacts)
    );

endmodule

// ----- sim/tb_short_range_pair_force.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_short_range_pair_force
// Self-checking bench for the cutoff pair force block: a directed table of
// pairs and register writes, then random near and far pairs under several
// register settings and idling patterns, checked by a local model or typed forces.
// ----------------------------------------------------------------------------
module tb_short_range_pair_force;
    import srpf_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;   // unmapped index, must be ignored
    localparam int         LIMIT_CYC  = 600000;
    localparam int         DRAIN_CYC  = 200;    // comfortably above the pipeline latency
    localparam int         SEG_ITEMS  = 135;

    typedef struct {
        logic [63:0] fx;
        logic [63:0] fy;
        logic        inter;
    } t_force;

    // one directed row: either a register write or a pair, optionally with a
    // force typed in by hand
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] data;
        logic [31:0] sx, sy, ox, oy;
        bit          typed;
        t_force      want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_self_x, i_self_y, i_other_x, i_other_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_force_x, o_force_y;
    logic        o_interacts;

    short_range_pair_force u_top (.*);

    // local copy of the registers, updated when a write beat lands
    logic [23:0] m_cutoff;
    logic [23:0] m_min_dist;
    logic [31:0] m_inv_mass;

    t_force pending_forces[$];
    t_row   dir_rows[$];
    int     mismatch_cnt;
    int     fail_cnt;
    int     cycle_cnt;
    int     send_gap_pct;
    int     stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // force model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res   = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v   = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // signed, truncated toward zero, saturated to 64 bits
    function automatic logic [63:0] axis_force(input logic [127:0] diff,
                                               input logic [127:0] delta,
                                               input logic [127:0] den,
                                               input bit neg);
        logic [127:0] num;
        logic [127:0] q;
        num = diff * delta;
        num = num * {96'd0, m_inv_mass};
        num = num << POS_FRAC_BITS;
        q   = num / den;
        if (q >= (128'd1 << 63))
            return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? (64'd0 - q[63:0]) : q[63:0];
    endfunction

    function automatic t_force pair_force(input logic [31:0] sx, input logic [31:0] sy,
                                          input logic [31:0] ox, input logic [31:0] oy);
        t_force      f;
        bit          negx, negy, negdiff;
        logic [63:0] adx, ady, r2, r, minsq, diff, cut;
        f    = '{64'd0, 64'd0, 1'b0};
        negx = ox < sx;
        negy = oy < sy;
        adx  = negx ? {32'd0, sx - ox} : {32'd0, ox - sx};
        ady  = negy ? {32'd0, sy - oy} : {32'd0, oy - sy};
        cut  = {40'd0, m_cutoff};
        if (adx > cut || ady > cut) return f;
        r2 = adx * adx + ady * ady;
        if (r2 > cut * cut) return f;
        f.inter = 1'b1;
        minsq = {40'd0, m_min_dist} * {40'd0, m_min_dist};
        if (r2 < minsq) r2 = minsq;
        if (r2 == 0) return f;           // coincident pair, no clamp
        r       = root_floor(r2);
        negdiff = r < cut;
        diff    = negdiff ? cut - r : r - cut;
        f.fx = axis_force({64'd0, diff}, {64'd0, adx}, {64'd0, r} * {64'd0, r2},
                          negdiff != negx);
        f.fy = axis_force({64'd0, diff}, {64'd0, ady}, {64'd0, r} * {64'd0, r2},
                          negdiff != negy);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // drivers; everything changes on the falling edge
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_CUTOFF:   m_cutoff   = data[23:0];
            CFG_MIN_DIST: m_min_dist = data[23:0];
            CFG_INV_MASS: m_inv_mass = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // valid stays up after the beat; the next call or a gap decides
    task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ox, input logic [31:0] oy,
                             input bit typed, input t_force want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_self_x   <= sx;
        i_self_y   <= sy;
        i_other_x  <= ox;
        i_other_y  <= oy;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_forces.insert(pending_forces.size(),
                              typed ? want : pair_force(sx, sy, ox, oy));
    endtask

    task automatic drain_and_park();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_row row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_force exp_f;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_forces.size() == 0) begin
                fail_cnt++;
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected force beat fx=%0d fy=%0d int=%0b",
                             $signed(o_force_x), $signed(o_force_y), o_interacts);
            end else begin
                exp_f = pending_forces.pop_front();
                if (o_force_x !== exp_f.fx || o_force_y !== exp_f.fy
                    || o_interacts !== exp_f.inter) begin
                    fail_cnt++;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("force mismatch: exp fx=%0d fy=%0d int=%0b, ",
                                 $signed(exp_f.fx), $signed(exp_f.fy), exp_f.inter,
                                 "got fx=%0d fy=%0d int=%0b",
                                 $signed(o_force_x), $signed(o_force_y), o_interacts);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYC) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic t_row pair_row(input logic [31:0] sx, input logic [31:0] sy,
                                      input logic [31:0] ox, input logic [31:0] oy,
                                      input bit typed, input t_force want);
        t_row row;
        row = '{1'b0, CFG_CUTOFF, 32'd0, sx, sy, ox, oy, typed, want};
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [31:0] data);
        t_row row;
        row = '{1'b1, idx, data, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, '{64'd0, 64'd0, 1'b0}};
        return row;
    endfunction

    initial begin
        t_force      none, touch, sat_lo, sat_hi, any;
        logic [31:0] base, sx, sy;
        int          span, offx, offy;
        logic [23:0] seg_cut[8];
        logic [23:0] seg_min[8];
        logic [31:0] seg_inv[8];

        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_CUTOFF;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_self_x     = '0;
        i_self_y     = '0;
        i_other_x    = '0;
        i_other_y    = '0;
        i_out_ready  = 1'b1;
        mismatch_cnt = 0;
        fail_cnt     = 0;
        cycle_cnt    = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        m_cutoff     = CUTOFF_RST;
        m_min_dist   = MIN_DIST_RST;
        m_inv_mass   = INV_MASS_RST;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        none   = '{64'd0, 64'd0, 1'b0};
        touch  = '{64'd0, 64'd0, 1'b1};
        sat_lo = '{64'h8000_0000_0000_0000, 64'd0, 1'b1};
        sat_hi = '{64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b1};
        any    = none;
        base   = 32'h4000_0000;

        // --- directed table, reset registers first ---
        // same spot: clamped, but zero offsets give zero force
        add_row(pair_row(0, 0, 0, 0, 1, touch));
        // opposite corners, far out of range
        add_row(pair_row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, none));
        add_row(pair_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, none));
        add_row(pair_row(base, base, base + 1000, base, 0, any));
        add_row(pair_row(base, base, base - 1000, base + 500, 0, any));
        // exactly on the cutoff, and one past it
        add_row(pair_row(base, base, base + CUTOFF_RST, base, 0, any));
        add_row(pair_row(base, base, base + CUTOFF_RST + 1, base, 1, none));
        // diagonal just inside and just outside the circle
        add_row(pair_row(base, base, base + 100000, base - 100000, 0, any));
        add_row(pair_row(base, base, base + 120000, base + 120000, 1, none));
        // closer than min distance: clamped
        add_row(pair_row(base, base, base + 1, base - 1, 0, any));
        // coincident with no clamp at all
        add_row(cfg_row(CFG_MIN_DIST, 32'd0));
        add_row(pair_row(base, base, base, base, 1, touch));
        // upper bits beyond the width are dropped
        add_row(cfg_row(CFG_CUTOFF, 32'hFFFF_FFFF));
        add_row(cfg_row(CFG_INV_MASS, 32'hFFFF_FFFF));
        // unit spacing at full cutoff and mass: quotient saturates
        add_row(pair_row(base, base, base + 1, base, 1, sat_lo));
        add_row(pair_row(base, base, base - 1, base, 1, sat_hi));
        add_row(pair_row(base, base, base + 32'h00FF_FFFF, base, 0, any));
        add_row(pair_row(base, base, base - 32'h00B5_0000, base + 32'h00B5_0000,
                         0, any));
        // unmapped register index leaves everything alone
        add_row(cfg_row(CFG_UNUSED, 32'h0000_0001));
        add_row(pair_row(base, base, base + 77777, base - 3, 0, any));
        add_row(cfg_row(CFG_INV_MASS, 32'd0));
        add_row(pair_row(base, base, base + 5000, base + 9000, 0, any));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_and_park();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_pair(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ox, dir_rows[i].oy,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // --- random segments, one register setting each ---
        seg_cut = '{CUTOFF_RST, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'h10_0000, 24'd0,
                    CUTOFF_RST};
        seg_min = '{MIN_DIST_RST, 24'd0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 24'd0,
                    MIN_DIST_RST};
        seg_inv = '{INV_MASS_RST, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'h0001_0000,
                    32'd0, INV_MASS_RST};
        foreach (seg_cut[s]) begin
            if (s == 3 || s == 4 || s == 6) begin
                seg_cut[s] = 24'($urandom_range(1, 24'hFF_FFFF));
                seg_min[s] = 24'($urandom_range(0, seg_cut[s] >> ((s == 4) ? 0 : 6)));
                seg_inv[s] = $urandom();
            end
            // let everything in flight come home before touching registers
            drain_and_park();
            send_gap_pct = 0;
            stall_pct    = 0;
            write_reg(CFG_CUTOFF, {8'd0, seg_cut[s]});
            write_reg(CFG_MIN_DIST, {8'd0, seg_min[s]});
            write_reg(CFG_INV_MASS, seg_inv[s]);
            case (s % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 79; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 79; end
                default: begin send_gap_pct = 36; stall_pct = 36; end
            endcase
            span = int'(m_cutoff) + int'(m_cutoff >> 2) + 2;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                // quiet from the middle of each segment to its end
                if (n == SEG_ITEMS / 2) begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                sx = $urandom();
                sy = $urandom();
                if ($urandom_range(0, 9) == 0) begin
                    send_pair(sx, sy, $urandom(), $urandom(), 0, any);
                end else begin
                    offx = $urandom_range(0, 2 * span) - span;
                    offy = $urandom_range(0, 2 * span) - span;
                    if ($urandom_range(0, 7) == 0) offx = 0;
                    if ($urandom_range(0, 7) == 0) offy = 0;
                    send_pair(sx, sy, sx + offx, sy + offy, 0, any);
                end
            end
        end

        drain_and_park();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_cnt == 0 && pending_forces.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/srpf_pkg.sv
rtl/core/srpf_front.sv
rtl/core/srpf_queue.sv
rtl/core/srpf_back.sv
rtl/core/short_range_pair_force.sv
sim/tb_short_range_pair_force.sv
